/* rtl/sprf_pkg.sv */
// Shared types and constants for the serial parameter frame receiver.
// Holds frame sync bytes, controller/datapath command and status structs.
// No dependencies.
package sprf_pkg;

    localparam int CMD_FRAME_LEN = 7;

    localparam logic [7:0] SYNC0     = 8'hFF;
    localparam logic [7:0] SYNC1     = 8'h55;
    localparam logic [7:0] SYNC2     = 8'hAA;
    localparam logic [7:0] KIND_DATA = 8'h10;
    localparam logic [7:0] KIND_CMD  = 8'h77;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    localparam logic FRAME_DATA = 1'b0;
    localparam logic FRAME_CMD  = 1'b1;

    typedef struct packed {
        logic accept;
        logic drop;
        logic clear_fill;
        logic scan_data;
        logic scan_cmd;
        logic chan_first;
        logic chan_next;
        logic put_data;
        logic put_cmd;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_full;
        logic fill_ge_data;
        logic fill_ge_cmd;
        logic done;
        logic hdr_ok;
        logic sum_ok;
        logic ch_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [7:0] hdr_byte(input logic [1:0] idx, input logic is_cmd);
        logic [7:0] b;
        case (idx)
            2'd0: b = SYNC0;
            2'd1: b = SYNC1;
            2'd2: b = SYNC2;
            default: b = is_cmd ? KIND_CMD : KIND_DATA;
        endcase
        return b;
    endfunction

endpackage

/* rtl/sprf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sprf_dp.sv */
// Datapath: byte buffer, fill count, window read walker, checksum and
// header check, channel word assembly and the output register.
// Depends on sprf_pkg and sprf_ram.
module sprf_dp #(
    parameter int BUFFER_LEN     = 128,
    parameter int CHANNELS       = 9,
    parameter int DATA_FRAME_LEN = 41
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sprf_pkg::t_dp_cmd  i_cmd,
    output sprf_pkg::t_dp_stat o_stat,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_stall,
    output logic               o_valid,
    output logic               o_frame_kind,
    output logic [3:0]         o_channel,
    output logic signed [31:0] o_channel_value,
    output logic [7:0]         o_cmd_number,
    output logic [7:0]         o_cmd_value,
    output logic               o_last
);
    import sprf_pkg::*;

    localparam int FW = $clog2(BUFFER_LEN + 1);
    localparam int AW = $clog2(BUFFER_LEN);
    localparam int OW = $clog2(DATA_FRAME_LEN + 4 * CHANNELS + 8);
    localparam int XW = $clog2(BUFFER_LEN + DATA_FRAME_LEN + 4 * CHANNELS + 8);

    logic [FW-1:0] r_fill;
    logic [7:0]    r_new;
    logic [FW-1:0] r_base;
    logic [OW-1:0] r_off;
    logic [OW-1:0] r_lim;
    logic          r_vld;
    logic [OW-1:0] r_voff;
    logic          r_voob;
    logic          r_scan;
    logic          r_is_cmd;
    logic [7:0]    r_sum;
    logic          r_hdr_ok;
    logic [31:0]   r_word;
    logic [7:0]    r_cnum;
    logic [7:0]    r_cval;
    logic [3:0]    r_ch;

    logic          r_ovld;
    logic          r_okind;
    logic [3:0]    r_och;
    logic [31:0]   r_oval;
    logic [7:0]    r_onum;
    logic [7:0]    r_ocval;
    logic          r_olast;

    logic          issue;
    logic [XW-1:0] addr_x;
    logic [7:0]    ram_q;
    logic [7:0]    rd_byte;
    logic [31:0]   chan_val;
    logic          scan_start;
    logic          ch_last;

    assign issue      = (r_off != r_lim);
    assign addr_x     = XW'(r_base) + XW'(r_off);
    assign rd_byte    = r_voob ? 8'h00 : ram_q;
    assign chan_val   = r_word[31] ? (POS_MAX - r_word) : r_word;
    assign scan_start = i_cmd.scan_data || i_cmd.scan_cmd;
    assign ch_last    = (r_ch == 4'(CHANNELS - 1));

    sprf_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_LEN)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (addr_x[AW-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        o_stat.fill_full    = (32'(r_fill) == BUFFER_LEN);
        o_stat.fill_ge_data = (32'(r_fill) >= DATA_FRAME_LEN);
        o_stat.fill_ge_cmd  = (32'(r_fill) >= CMD_FRAME_LEN);
        o_stat.done         = !issue && !r_vld;
        o_stat.hdr_ok       = r_hdr_ok;
        o_stat.sum_ok       = (r_sum == r_new);
        o_stat.ch_last      = ch_last;
        o_stat.out_free     = !r_ovld || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_off  <= '0;
            r_lim  <= '0;
            r_vld  <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_fill <= r_fill + FW'(1);
            end else if (i_cmd.drop || i_cmd.clear_fill) begin
                r_fill <= '0;
            end
            r_vld <= issue;
            if (scan_start) begin
                r_off <= '0;
                r_lim <= i_cmd.scan_data ? OW'(DATA_FRAME_LEN - 1) : OW'(CMD_FRAME_LEN - 1);
            end else if (i_cmd.chan_first) begin
                r_off <= OW'(4);
                r_lim <= OW'(8);
            end else if (i_cmd.chan_next) begin
                r_lim <= r_lim + OW'(4);
            end else if (issue) begin
                r_off <= r_off + OW'(1);
            end
            if (i_cmd.put_data || i_cmd.put_cmd) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_new <= i_rx_byte;
        end
        r_voff <= r_off;
        r_voob <= (32'(addr_x) >= BUFFER_LEN);
        if (scan_start) begin
            r_base   <= FW'(32'(r_fill) - (i_cmd.scan_data ? DATA_FRAME_LEN : CMD_FRAME_LEN));
            r_sum    <= '0;
            r_hdr_ok <= 1'b1;
            r_is_cmd <= i_cmd.scan_cmd;
            r_scan   <= 1'b1;
            r_ch     <= '0;
        end else if (i_cmd.chan_first) begin
            r_scan <= 1'b0;
        end
        if (r_vld) begin
            if (r_scan) begin
                r_sum <= r_sum + rd_byte;
                if ((r_voff < OW'(4)) && (rd_byte != hdr_byte(r_voff[1:0], r_is_cmd))) begin
                    r_hdr_ok <= 1'b0;
                end
                if (r_voff == OW'(4)) begin
                    r_cnum <= rd_byte;
                end
                if (r_voff == OW'(5)) begin
                    r_cval <= rd_byte;
                end
            end else begin
                r_word <= {r_word[23:0], rd_byte};
            end
        end
        if (i_cmd.put_data) begin
            r_okind <= FRAME_DATA;
            r_och   <= r_ch;
            r_oval  <= chan_val;
            r_onum  <= '0;
            r_ocval <= '0;
            r_olast <= ch_last;
            r_ch    <= r_ch + 4'd1;
        end else if (i_cmd.put_cmd) begin
            r_okind <= FRAME_CMD;
            r_och   <= '0;
            r_oval  <= '0;
            r_onum  <= r_cnum;
            r_ocval <= r_cval;
            r_olast <= 1'b1;
        end
    end

    assign o_valid         = r_ovld;
    assign o_frame_kind    = r_okind;
    assign o_channel       = r_och;
    assign o_channel_value = signed'(r_oval);
    assign o_cmd_number    = r_onum;
    assign o_cmd_value     = r_ocval;
    assign o_last          = r_olast;

endmodule

/* rtl/sprf_ctrl.sv */
// Controller: sequences byte append, data and command window scans and
// result emission. Drives datapath commands from datapath status.
// Depends on sprf_pkg.
module sprf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sprf_pkg::t_dp_stat i_stat,
    output sprf_pkg::t_dp_cmd  o_cmd
);
    import sprf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_DSCAN = 3'd2;
    localparam logic [2:0] S_CSCAN = 3'd3;
    localparam logic [2:0] S_DRD   = 3'd4;
    localparam logic [2:0] S_DPUT  = 3'd5;
    localparam logic [2:0] S_CPUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_stat.fill_full) begin
                        o_cmd.drop = 1'b1;
                    end else begin
                        o_cmd.accept = 1'b1;
                        n_state      = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (i_stat.fill_ge_data) begin
                    o_cmd.scan_data = 1'b1;
                    n_state         = S_DSCAN;
                end else if (i_stat.fill_ge_cmd) begin
                    o_cmd.scan_cmd = 1'b1;
                    n_state        = S_CSCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DSCAN: begin
                if (i_stat.done) begin
                    if (i_stat.hdr_ok) begin
                        if (i_stat.sum_ok) begin
                            o_cmd.chan_first = 1'b1;
                            n_state          = S_DRD;
                        end else begin
                            o_cmd.clear_fill = 1'b1;
                            n_state          = S_IDLE;
                        end
                    end else if (i_stat.fill_ge_cmd) begin
                        o_cmd.scan_cmd = 1'b1;
                        n_state        = S_CSCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CSCAN: begin
                if (i_stat.done) begin
                    if (i_stat.hdr_ok) begin
                        o_cmd.clear_fill = 1'b1;
                        n_state          = i_stat.sum_ok ? S_CPUT : S_IDLE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DRD: begin
                if (i_stat.done) begin
                    n_state = S_DPUT;
                end
            end
            S_DPUT: begin
                if (i_stat.out_free) begin
                    o_cmd.put_data = 1'b1;
                    if (i_stat.ch_last) begin
                        o_cmd.clear_fill = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.chan_next = 1'b1;
                        n_state         = S_DRD;
                    end
                end
            end
            S_CPUT: begin
                if (i_stat.out_free) begin
                    o_cmd.put_cmd = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

/* rtl/serial_param_frame_receiver_core.sv */
// Serial parameter frame receiver: appends bytes to a buffer and emits
// channel values or a command when a checked frame ends on the newest byte.
// Input bytes are taken one at a time: o_stall holds off the next byte
// while the buffer RAM read port walks the frame window one byte a cycle
// and while the channel words of a good data frame are read and emitted.
// Synchronous active-low reset empties the buffer; its contents stay stale.
module serial_param_frame_receiver_core #(
    parameter int BUFFER_LEN     = 128,
    parameter int CHANNELS       = 9,
    parameter int DATA_FRAME_LEN = 41
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_frame_kind,
    output logic [3:0]         o_channel,
    output logic signed [31:0] o_channel_value,
    output logic [7:0]         o_cmd_number,
    output logic [7:0]         o_cmd_value,
    output logic               o_last
);
    import sprf_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sprf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    sprf_dp #(
        .BUFFER_LEN     (BUFFER_LEN),
        .CHANNELS       (CHANNELS),
        .DATA_FRAME_LEN (DATA_FRAME_LEN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_rx_byte       (i_rx_byte),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_frame_kind    (o_frame_kind),
        .o_channel       (o_channel),
        .o_channel_value (o_channel_value),
        .o_cmd_number    (o_cmd_number),
        .o_cmd_value     (o_cmd_value),
        .o_last          (o_last)
    );

endmodule
